FILE: rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define CHK_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define CHK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/pct_pkg.sv
// shared constants and types of the perceptron block
`default_nettype none

package pct_pkg;

	localparam int NUM_WEIGHTS       = 3;
	localparam int FEATURE_WIDTH_DEF = 16;
	localparam int WEIGHT_WIDTH_DEF  = 32;
	localparam int RATE_W            = 16;
	localparam int CNT_W             = 16;
	localparam int CFG_W             = 16;
	localparam int CFG_IDX_W         = 1;

	localparam logic [RATE_W-1:0] LEARNING_RATE_RST   = 16'd655;
	localparam logic [CNT_W-1:0]  MAX_GENERATIONS_RST = 16'd0;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LEARNING_RATE,
		REG_MAX_GENERATIONS
	} cfg_reg_t;

	typedef struct packed {
		logic load;
		logic update;
		logic positive;
	} lane_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/perceptron_classify_train.sv
// An input transfer loads the lane product registers; the merged sign and the weight
// write-back follow on commit, which writes the output register and waits while an
// untaken result is held. A new item is taken only after the last one is committed.
// A waiting result does not block the next input transfer.
// Reset clears the weights, epoch and generation counters, the done flag and
// sets learning_rate to 655 and max_generations to 0.
`default_nettype none

module perceptron_classify_train #(
	parameter int FEATURE_WIDTH = pct_pkg::FEATURE_WIDTH_DEF,
	parameter int WEIGHT_WIDTH  = pct_pkg::WEIGHT_WIDTH_DEF
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  cfg_wr_en,
	input  wire logic [pct_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [pct_pkg::CFG_W-1:0]       cfg_data,
	input  wire                                  in_valid,
	output logic                                 in_ready,
	input  wire                                  func,
	input  wire logic signed [FEATURE_WIDTH-1:0] feature_0,
	input  wire logic signed [FEATURE_WIDTH-1:0] feature_1,
	input  wire logic signed [FEATURE_WIDTH-1:0] feature_2,
	input  wire                                  target_positive,
	input  wire                                  last_of_epoch,
	output logic                                 out_valid,
	input  wire                                  out_ready,
	output logic                                 prediction_positive,
	output logic                                 mistake,
	output logic [pct_pkg::CNT_W-1:0]            epoch_errors,
	output logic [pct_pkg::CNT_W-1:0]            generation_count,
	output logic                                 training_done
);

	localparam int N  = pct_pkg::NUM_WEIGHTS;
	localparam int PW = FEATURE_WIDTH + WEIGHT_WIDTH;

	logic signed [FEATURE_WIDTH-1:0] feat [N];
	logic signed [PW-1:0]            prod_s1 [N];
	pct_pkg::lane_ctrl_t             lane_ctrl;

	logic [pct_pkg::RATE_W-1:0] rate_q;
	logic [pct_pkg::CNT_W-1:0]  max_gen_q;
	logic [pct_pkg::CNT_W-1:0]  err_cnt_q;
	logic [pct_pkg::CNT_W-1:0]  gen_cnt_q;
	logic                       done_q;
	logic                       busy_q;
	logic                       out_valid_q;
	logic                       func_s1;
	logic                       target_s1;
	logic                       last_s1;
	logic                       pred_q;
	logic                       mistake_q;
	logic [pct_pkg::CNT_W-1:0]  errs_q;
	logic [pct_pkg::CNT_W-1:0]  gen_q;
	logic                       done_out_q;

	logic                       in_xfer;
	logic                       commit;
	logic                       guess;
	logic                       train;
	logic                       miss;
	logic                       epoch_end;
	logic [pct_pkg::CNT_W-1:0]  errs_new;
	logic [pct_pkg::CNT_W-1:0]  gen_new;
	logic                       done_new;

	assign feat[0] = feature_0;
	assign feat[1] = feature_1;
	assign feat[2] = feature_2;

	assign in_ready = !busy_q;
	assign in_xfer  = in_valid && in_ready;
	assign commit   = busy_q && (!out_valid_q || out_ready);

	assign lane_ctrl.load     = in_xfer;
	assign lane_ctrl.update   = commit && miss;
	assign lane_ctrl.positive = target_s1;

	for (genvar i = 0; i < N; i++) begin : g_lane
		pct_lane #(
			.FEATURE_WIDTH(FEATURE_WIDTH),
			.WEIGHT_WIDTH (WEIGHT_WIDTH)
		) u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (lane_ctrl),
			.feature(feat[i]),
			.rate   (rate_q),
			.prod_s1(prod_s1[i])
		);
	end

	pct_merge #(
		.FEATURE_WIDTH(FEATURE_WIDTH),
		.WEIGHT_WIDTH (WEIGHT_WIDTH)
	) u_merge (
		.prod (prod_s1),
		.guess(guess)
	);

	always_comb begin
		train     = func_s1 && !done_q;
		miss      = train && (guess != target_s1);
		epoch_end = train && last_s1;
		errs_new  = err_cnt_q;
		if (miss && err_cnt_q != '1) begin
			errs_new = err_cnt_q + 1'b1;
		end
		gen_new  = gen_cnt_q;
		done_new = done_q;
		if (epoch_end) begin
			if (gen_cnt_q != '1) begin
				gen_new = gen_cnt_q + 1'b1;
			end
			if (errs_new == '0 || (max_gen_q != '0 && gen_new >= max_gen_q)) begin
				done_new = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q    <= pct_pkg::LEARNING_RATE_RST;
			max_gen_q <= pct_pkg::MAX_GENERATIONS_RST;
		end else if (cfg_wr_en) begin
			case (pct_pkg::cfg_reg_t'(cfg_index))
				pct_pkg::REG_LEARNING_RATE:   rate_q    <= cfg_data;
				pct_pkg::REG_MAX_GENERATIONS: max_gen_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
			err_cnt_q   <= '0;
			gen_cnt_q   <= '0;
			done_q      <= 1'b0;
		end else begin
			if (in_xfer) begin
				busy_q <= 1'b1;
			end else if (commit) begin
				busy_q <= 1'b0;
			end
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (commit) begin
				err_cnt_q <= epoch_end ? '0 : errs_new;
				gen_cnt_q <= gen_new;
				done_q    <= done_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			func_s1   <= func;
			target_s1 <= target_positive;
			last_s1   <= last_of_epoch;
		end
		if (commit) begin
			pred_q     <= guess;
			mistake_q  <= miss;
			errs_q     <= errs_new;
			gen_q      <= gen_new;
			done_out_q <= done_new;
		end
	end

	assign out_valid           = out_valid_q;
	assign prediction_positive = pred_q;
	assign mistake             = mistake_q;
	assign epoch_errors        = errs_q;
	assign generation_count    = gen_q;
	assign training_done       = done_out_q;

endmodule

`default_nettype wire

FILE: rtl/pct_lane.sv
// one weight lane: stored weight, product, rate product and saturating update
`default_nettype none

module pct_lane #(
	parameter int FEATURE_WIDTH = pct_pkg::FEATURE_WIDTH_DEF,
	parameter int WEIGHT_WIDTH  = pct_pkg::WEIGHT_WIDTH_DEF
) (
	input  wire                                         clk,
	input  wire                                         arst_n,
	input  wire pct_pkg::lane_ctrl_t                    ctrl,
	input  wire logic signed [FEATURE_WIDTH-1:0]        feature,
	input  wire logic [pct_pkg::RATE_W-1:0]             rate,
	output logic signed [FEATURE_WIDTH+WEIGHT_WIDTH-1:0] prod_s1
);

	localparam int PW  = FEATURE_WIDTH + WEIGHT_WIDTH;
	localparam int RPW = FEATURE_WIDTH + pct_pkg::RATE_W + 1;
	localparam int DW  = RPW + 1;
	localparam int QW  = DW - 8;
	localparam int SW  = ((WEIGHT_WIDTH > QW) ? WEIGHT_WIDTH : QW) + 1;

	logic signed [WEIGHT_WIDTH-1:0] weight_q;
	logic signed [RPW-1:0]          fr_s1;
	logic signed [PW-1:0]           prod_w;
	logic signed [RPW-1:0]          fr_w;
	logic signed [DW-1:0]           fr_x;
	logic signed [DW-1:0]           raw_plus;
	logic signed [DW-1:0]           raw_minus;
	logic signed [QW-1:0]           d_plus;
	logic signed [QW-1:0]           d_minus;
	logic signed [SW-1:0]           sum_plus;
	logic signed [SW-1:0]           sum_minus;
	logic signed [WEIGHT_WIDTH-1:0] sat_plus;
	logic signed [WEIGHT_WIDTH-1:0] sat_minus;

	function automatic logic signed [WEIGHT_WIDTH-1:0] sat_w(input logic signed [SW-1:0] v);
		logic [SW-WEIGHT_WIDTH:0] top;
		top = v[SW-1:WEIGHT_WIDTH-1];
		if (top == '0 || top == '1) begin
			return v[WEIGHT_WIDTH-1:0];
		end else if (v[SW-1]) begin
			return {1'b1, {(WEIGHT_WIDTH-1){1'b0}}};
		end else begin
			return {1'b0, {(WEIGHT_WIDTH-1){1'b1}}};
		end
	endfunction

	assign prod_w = PW'(weight_q) * PW'(feature);
	assign fr_w   = RPW'(feature) * $signed({1'b0, rate});

	// round half up of the q8.24 update term to q16.16
	assign fr_x      = DW'(fr_s1);
	assign raw_plus  = fr_x + fr_x + DW'(128);
	assign raw_minus = DW'(128) - fr_x - fr_x;
	assign d_plus    = raw_plus[DW-1:8];
	assign d_minus   = raw_minus[DW-1:8];
	assign sum_plus  = SW'(weight_q) + SW'(d_plus);
	assign sum_minus = SW'(weight_q) + SW'(d_minus);
	assign sat_plus  = sat_w(sum_plus);
	assign sat_minus = sat_w(sum_minus);

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			prod_s1 <= prod_w;
			fr_s1   <= fr_w;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q <= '0;
		end else if (ctrl.update) begin
			weight_q <= ctrl.positive ? sat_plus : sat_minus;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/pct_merge.sv
// merging stage: adds the lane products and takes the sign
`default_nettype none

module pct_merge #(
	parameter int FEATURE_WIDTH = pct_pkg::FEATURE_WIDTH_DEF,
	parameter int WEIGHT_WIDTH  = pct_pkg::WEIGHT_WIDTH_DEF
) (
	input  wire logic signed [FEATURE_WIDTH+WEIGHT_WIDTH-1:0] prod [pct_pkg::NUM_WEIGHTS],
	output logic                                              guess
);

	localparam int PW   = FEATURE_WIDTH + WEIGHT_WIDTH;
	localparam int SUMW = PW + $clog2(pct_pkg::NUM_WEIGHTS);

	logic signed [SUMW-1:0] acc;

	always_comb begin
		acc = '0;
		for (int i = 0; i < pct_pkg::NUM_WEIGHTS; i++) begin
			acc = acc + SUMW'(prod[i]);
		end
		guess = !acc[SUMW-1] && (acc != '0);
	end

endmodule

`default_nettype wire

FILE: rtl/pct_checker.sv
// port-level checker for the perceptron block and its bind
`default_nettype none

`include "assert_macros.svh"

module pct_checker (
	input wire                        clk,
	input wire                        arst_n,
	input wire                        in_valid,
	input wire                        in_ready,
	input wire                        out_valid,
	input wire                        out_ready,
	input wire                        mistake,
	input wire [pct_pkg::CNT_W-1:0]   epoch_errors,
	input wire                        training_done
);

	logic done_seen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_seen_q <= 1'b0;
		end else if (out_valid && out_ready && training_done) begin
			done_seen_q <= 1'b1;
		end
	end

	`CHK_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped before transfer")
	`CHK_NEXT(a_err_stable, out_valid && !out_ready, $stable(epoch_errors), "stalled result changed")
	`CHK_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready, "second item taken while busy")
	`CHK_IMPLY(a_done_sticky, out_valid && done_seen_q, training_done && !mistake, "training resumed after done")

endmodule

bind perceptron_classify_train pct_checker u_pct_checker (.*);

`default_nettype wire
